>>> rtl/midi_to_fm_register_writes_defines.svh
// Assertion macros used by the checker file.
`ifndef MIDI_TO_FM_REGISTER_WRITES_DEFINES_SVH
`define MIDI_TO_FM_REGISTER_WRITES_DEFINES_SVH

// Property checked outside reset
`define MTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked during reset as well
`define MTF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/mtf_pkg.sv
// Types, codes and tables for the MIDI to FM register write block.
package mtf_pkg;

    typedef enum logic [2:0] {
        ST_IDLE, ST_FREE, ST_AGE, ST_STEAL, ST_FETCH, ST_PLAY, ST_STOP, ST_REL
    } state_t;

    localparam logic [1:0] OP_MIDI  = 2'd0;
    localparam logic [1:0] OP_PATCH = 2'd1;
    localparam logic [1:0] OP_RESET = 2'd2;

    localparam logic [3:0] KIND_NOTE_OFF = 4'h8;
    localparam logic [3:0] KIND_NOTE_ON  = 4'h9;
    localparam logic [3:0] KIND_CTRL     = 4'hB;
    localparam logic [3:0] KIND_PROGRAM  = 4'hC;
    localparam logic [3:0] KIND_PRESSURE = 4'hD;

    localparam logic [7:0] SYSEX_START   = 8'hF0;
    localparam logic [7:0] SYSEX_END     = 8'hF7;
    localparam logic [7:0] REALTIME_BASE = 8'hF8;
    localparam logic [7:0] CC_ALL_OFF    = 8'd123;

    localparam logic [7:0] REG_FEEDBACK = 8'hC0;
    localparam logic [7:0] REG_FNUM_LO  = 8'hA0;
    localparam logic [7:0] REG_KEY      = 8'hB0;
    localparam logic [7:0] FB_FORCE     = 8'h30;
    localparam logic [7:0] KEY_ON_BIT   = 8'h20;

    localparam logic [3:0] STEP_FEEDBACK = 4'd10;
    localparam logic [3:0] STEP_FNUM     = 4'd11;
    localparam logic [3:0] STEP_KEYON    = 4'd12;
    localparam logic [3:0] PATCH_BYTES   = 4'd11;

    localparam logic [7:0] MOD_SLOT [9] = '{8'h00, 8'h01, 8'h02, 8'h08, 8'h09,
                                            8'h0A, 8'h10, 8'h11, 8'h12};
    localparam logic [7:0] CAR_SLOT [9] = '{8'h03, 8'h04, 8'h05, 8'h0B, 8'h0C,
                                            8'h0D, 8'h13, 8'h14, 8'h15};

    // Data bytes a status takes, counting the status itself
    function automatic logic [1:0] need_for(input logic [7:0] status);
        return (status[7:4] == KIND_PROGRAM || status[7:4] == KIND_PRESSURE) ? 2'd2 : 2'd3;
    endfunction

    // Patch byte read at each write step
    function automatic logic [3:0] patch_pos(input logic [3:0] step);
        case (step)
            4'd0:    return 4'd0;
            4'd1:    return 4'd4;
            4'd2:    return 4'd1;
            4'd3:    return 4'd2;
            4'd4:    return 4'd3;
            4'd5:    return 4'd7;
            4'd6:    return 4'd10;
            4'd7:    return 4'd8;
            4'd8:    return 4'd9;
            4'd9:    return 4'd5;
            default: return 4'd6;
        endcase
    endfunction

    // Operator register group of a step
    function automatic logic [7:0] reg_base(input logic [3:0] step);
        case (step)
            4'd0, 4'd5: return 8'h20;
            4'd1, 4'd6: return 8'h40;
            4'd2, 4'd7: return 8'h60;
            4'd3, 4'd8: return 8'h80;
            default:    return 8'hE0;
        endcase
    endfunction

    function automatic logic [9:0] fnum(input logic [3:0] semi);
        case (semi)
            4'd0:    return 10'h158;
            4'd1:    return 10'h16D;
            4'd2:    return 10'h183;
            4'd3:    return 10'h19A;
            4'd4:    return 10'h1B2;
            4'd5:    return 10'h1CC;
            4'd6:    return 10'h1E7;
            4'd7:    return 10'h204;
            4'd8:    return 10'h223;
            4'd9:    return 10'h244;
            4'd10:   return 10'h267;
            default: return 10'h28D;
        endcase
    endfunction

    // note / 12 by reciprocal, exact for 7-bit notes
    function automatic logic [3:0] octave(input logic [6:0] note);
        logic [14:0] prod;
        prod = 15'(note) * 15'd171;
        return prod[14:11];
    endfunction

endpackage

>>> rtl/mtf_ram.sv
// Generic single-port-write, registered-read RAM.
module mtf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/midi_to_fm_register_writes.sv
// Top level: MIDI byte parser, voice allocator and FM register write sequencer.
//
// Input channel s_*: one beat is a MIDI byte, a patch store byte write or a
// voice/parser reset. Output channel m_*: one beat per FM register write;
// m_last_write marks the final write caused by an input beat. cfg_* writes
// the patches-valid flag, accepted in every cycle; change it only when idle.
// s_ready is high only while the sequencer is idle, so one beat is worked on
// at a time. A note-on scans the voices one per cycle (first for a free voice,
// then, when all are busy, for the oldest, which is stolen with a key-off),
// then emits its writes through one output register: each of the eleven
// patch writes is read from the RAM in a fetch state and emitted in a play
// state, followed by the F-number and key-on writes. Key-off scans go through
// the voices in index order. A stalled receiver holds the output register
// and stalls the sequencer at its next write; nothing is dropped. Reset
// clears the parser, voices, ages, programs and the output valid flag; the
// patch RAM is not cleared and must be loaded before it is played.
module midi_to_fm_register_writes
    import mtf_pkg::*;
#(
    parameter int VOICES      = 9,
    parameter int PATCH_COUNT = 128
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_patches_valid,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_opcode,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_of_chunk,
    input  logic [6:0] s_patch_number,
    input  logic [3:0] s_patch_byte_position,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_register_address,
    output logic [7:0] m_register_value,
    output logic       m_last_write
);

    localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PN_W   = (PATCH_COUNT > 1) ? $clog2(PATCH_COUNT) : 1;
    localparam int RAM_AW = PN_W + 4;
    localparam logic [VIDX_W-1:0] VLAST = VIDX_W'(VOICES - 1);

    state_t state_reg, state_next;

    // parser
    logic [7:0] rs_reg, rs_next;
    logic [1:0] held_reg, held_next;
    logic [1:0] need_reg, need_next;
    logic [7:0] fdb_reg, fdb_next;
    logic       sysex_reg, sysex_next;
    logic       pv_reg;

    // voices
    logic        in_use_reg [VOICES];
    logic [3:0]  vch_reg    [VOICES];
    logic [6:0]  vnote_reg  [VOICES];
    logic [31:0] vage_reg   [VOICES];
    logic [31:0] age_cnt_reg;
    logic [6:0]  prog_tab_reg [16];

    // sequencer
    logic [VIDX_W-1:0] idx_reg, idx_next;
    logic [VIDX_W-1:0] pick_reg, pick_next;
    logic [3:0]        step_reg, step_next;
    logic [3:0]        ch_reg, ch_next;
    logic [6:0]        note_reg, note_next;
    logic [PN_W-1:0]   prog_reg, prog_next;
    logic              rel_all_reg, rel_all_next;

    // output register
    logic       mv_reg, mv_next;
    logic [7:0] ma_reg, ma_next;
    logic [7:0] md_reg, md_next;
    logic       ml_reg, ml_next;

    // decode
    logic       accept, slot_free;
    logic [1:0] h, n;
    logic       go;
    logic [7:0] d1, d2;
    logic       act_start, act_stop, act_prog, act_rel;
    logic [VOICES-1:0] rel_match, stop_match;
    logic       later;
    logic       emit;
    logic [7:0] e_addr, e_val;
    logic       e_last;
    logic       do_claim;
    logic [VIDX_W-1:0] claim_v;
    logic       do_free;
    logic [VIDX_W-1:0] free_v;
    logic [6:0] chp;
    logic [9:0] fn;
    logic [3:0] blk;
    logic [3:0] semi;

    // patch RAM
    logic              ram_we, ram_re;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_rdata;

    assign accept    = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign slot_free = !mv_reg || m_ready;

    assign m_valid            = mv_reg;
    assign m_register_address = ma_reg;
    assign m_register_value   = md_reg;
    assign m_last_write       = ml_reg;

    // Patch byte writes
    assign ram_we    = accept && s_opcode == OP_PATCH
                       && 32'(s_patch_number) < PATCH_COUNT
                       && s_patch_byte_position < PATCH_BYTES;
    assign ram_waddr = {s_patch_number[PN_W-1:0], s_patch_byte_position};
    assign ram_re    = (state_reg == ST_FETCH);
    assign ram_raddr = {prog_reg, patch_pos(step_reg)};

    mtf_ram #(
        .WIDTH (8),
        .DEPTH ((1 << PN_W) * 16)
    ) u_patch_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_data_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Voice match vectors for key-off scans
    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            rel_match[i]  = in_use_reg[i] && (rel_all_reg || vch_reg[i] == ch_reg);
            stop_match[i] = in_use_reg[i] && vch_reg[i] == ch_reg
                            && vnote_reg[i] == note_reg;
        end
        later = 1'b0;
        for (int i = 0; i < VOICES; i++) begin
            if (VIDX_W'(i) > idx_reg && rel_match[i]) begin
                later = 1'b1;
            end
        end
    end

    // Running-status parser
    always_comb begin
        rs_next    = rs_reg;
        held_next  = held_reg;
        need_next  = need_reg;
        fdb_next   = fdb_reg;
        sysex_next = sysex_reg;
        h          = held_reg;
        n          = need_reg;
        go         = 1'b0;
        d1         = s_data_byte;
        d2         = 8'd0;
        act_start  = 1'b0;
        act_stop   = 1'b0;
        act_prog   = 1'b0;
        act_rel    = 1'b0;
        if (accept && s_opcode == OP_MIDI) begin
            if (sysex_reg) begin
                if (s_data_byte == SYSEX_END || s_last_of_chunk) begin
                    sysex_next = 1'b0;
                end
            end else if (s_data_byte[7]) begin
                if (s_data_byte >= REALTIME_BASE) begin
                    sysex_next = sysex_reg;
                end else if (s_data_byte == SYSEX_START || s_data_byte == SYSEX_END) begin
                    rs_next    = 8'd0;
                    held_next  = 2'd0;
                    sysex_next = (s_data_byte == SYSEX_START) && !s_last_of_chunk;
                end else begin
                    rs_next   = s_data_byte;
                    held_next = 2'd1;
                    need_next = need_for(s_data_byte);
                end
            end else begin
                go = 1'b1;
                if (held_reg == 2'd0) begin
                    if (rs_reg == 8'd0) begin
                        go = 1'b0;
                    end else begin
                        h         = 2'd1;
                        n         = need_for(rs_reg);
                        held_next = h;
                        need_next = n;
                    end
                end
                if (go && h < n) begin
                    if (h == 2'd1 && n == 2'd3) begin
                        fdb_next  = s_data_byte;
                        held_next = 2'd2;
                    end else begin
                        held_next = 2'd1;
                        if (n == 2'd2) begin
                            d1 = s_data_byte;
                            d2 = 8'd0;
                        end else begin
                            d1 = fdb_reg;
                            d2 = s_data_byte;
                        end
                        // message dispatch
                        case (rs_reg[7:4])
                            KIND_NOTE_ON: begin
                                act_start = (d2 != 8'd0) && pv_reg;
                                act_stop  = (d2 == 8'd0);
                            end
                            KIND_NOTE_OFF: act_stop = 1'b1;
                            KIND_PROGRAM:  act_prog = 1'b1;
                            KIND_CTRL:     act_rel  = (d1 == CC_ALL_OFF);
                            default:       act_prog = 1'b0;
                        endcase
                    end
                end
            end
        end else if (accept && s_opcode == OP_RESET) begin
            rs_next    = 8'd0;
            held_next  = 2'd0;
            need_next  = 2'd0;
            sysex_next = 1'b0;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (act_start) begin
                    state_next = ST_FREE;
                end else if (act_stop) begin
                    state_next = ST_STOP;
                end else if (act_rel || (accept && s_opcode == OP_RESET)) begin
                    state_next = ST_REL;
                end
            end
            ST_FREE: begin
                if (!in_use_reg[idx_reg]) begin
                    state_next = ST_FETCH;
                end else if (idx_reg == VLAST) begin
                    state_next = (VOICES > 1) ? ST_AGE : ST_STEAL;
                end
            end
            ST_AGE: begin
                if (idx_reg == VLAST) begin
                    state_next = ST_STEAL;
                end
            end
            ST_STEAL: begin
                if (slot_free) begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH: state_next = ST_PLAY;
            ST_PLAY: begin
                if (slot_free) begin
                    if (step_reg == STEP_KEYON) begin
                        state_next = ST_IDLE;
                    end else if (step_reg < STEP_FEEDBACK - 4'd1) begin
                        state_next = ST_FETCH;
                    end else if (step_reg == STEP_FEEDBACK - 4'd1) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_STOP: begin
                if (stop_match[idx_reg]) begin
                    if (slot_free) begin
                        state_next = ST_IDLE;
                    end
                end else if (idx_reg == VLAST) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REL: begin
                if (rel_match[idx_reg]) begin
                    if (slot_free && !later) begin
                        state_next = ST_IDLE;
                    end
                end else if (idx_reg == VLAST) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Note-on pitch
    assign semi = 4'(note_reg - 7'(octave(note_reg)) * 7'd12);
    assign fn   = fnum(semi);
    assign blk  = (octave(note_reg) > 4'd7) ? 4'd7 : octave(note_reg);
    assign chp  = prog_tab_reg[rs_reg[3:0]];

    // Sequencer datapath and register writes
    always_comb begin
        idx_next     = idx_reg;
        pick_next    = pick_reg;
        step_next    = step_reg;
        ch_next      = ch_reg;
        note_next    = note_reg;
        prog_next    = prog_reg;
        rel_all_next = rel_all_reg;
        emit         = 1'b0;
        e_addr       = 8'd0;
        e_val        = 8'd0;
        e_last       = 1'b0;
        do_claim     = 1'b0;
        claim_v      = pick_reg;
        do_free      = 1'b0;
        free_v       = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                idx_next     = '0;
                ch_next      = rs_reg[3:0];
                note_next    = d1[6:0];
                rel_all_next = (s_opcode == OP_RESET);
                prog_next    = (32'(chp) < PATCH_COUNT) ? chp[PN_W-1:0] : '0;
            end
            ST_FREE: begin
                if (!in_use_reg[idx_reg]) begin
                    pick_next = idx_reg;
                    do_claim  = 1'b1;
                    claim_v   = idx_reg;
                end else if (idx_reg == VLAST) begin
                    pick_next = '0;
                    idx_next  = VIDX_W'(1);
                end else begin
                    idx_next = idx_reg + VIDX_W'(1);
                end
            end
            ST_AGE: begin
                if (vage_reg[idx_reg] < vage_reg[pick_reg]) begin
                    pick_next = idx_reg;
                end
                idx_next = idx_reg + VIDX_W'(1);
            end
            ST_STEAL: begin
                if (slot_free) begin
                    emit     = 1'b1;
                    e_addr   = REG_KEY + 8'(pick_reg);
                    do_claim = 1'b1;
                end
            end
            ST_FETCH: begin
                step_next = step_reg;
            end
            ST_PLAY: begin
                if (slot_free) begin
                    emit      = 1'b1;
                    step_next = step_reg + 4'd1;
                    if (step_reg < 4'd5) begin
                        e_addr = reg_base(step_reg) + MOD_SLOT[4'(pick_reg)];
                        e_val  = ram_rdata;
                    end else if (step_reg < STEP_FEEDBACK) begin
                        e_addr = reg_base(step_reg) + CAR_SLOT[4'(pick_reg)];
                        e_val  = ram_rdata;
                    end else if (step_reg == STEP_FEEDBACK) begin
                        e_addr = REG_FEEDBACK + 8'(pick_reg);
                        e_val  = ram_rdata | FB_FORCE;
                    end else if (step_reg == STEP_FNUM) begin
                        e_addr = REG_FNUM_LO + 8'(pick_reg);
                        e_val  = fn[7:0];
                    end else begin
                        e_addr = REG_KEY + 8'(pick_reg);
                        e_val  = KEY_ON_BIT | {3'd0, blk[2:0], fn[9:8]};
                        e_last = 1'b1;
                    end
                end
            end
            ST_STOP: begin
                if (stop_match[idx_reg]) begin
                    if (slot_free) begin
                        emit    = 1'b1;
                        e_addr  = REG_KEY + 8'(idx_reg);
                        e_last  = 1'b1;
                        do_free = 1'b1;
                    end
                end else begin
                    idx_next = idx_reg + VIDX_W'(1);
                end
            end
            ST_REL: begin
                if (rel_match[idx_reg]) begin
                    if (slot_free) begin
                        emit     = 1'b1;
                        e_addr   = REG_KEY + 8'(idx_reg);
                        e_last   = !later;
                        do_free  = 1'b1;
                        idx_next = idx_reg + VIDX_W'(1);
                    end
                end else begin
                    idx_next = idx_reg + VIDX_W'(1);
                end
            end
            default: idx_next = '0;
        endcase
        if (do_claim) begin
            step_next = '0;
        end
    end

    // Output register
    always_comb begin
        mv_next = mv_reg;
        ma_next = ma_reg;
        md_next = md_reg;
        ml_next = ml_reg;
        if (emit) begin
            mv_next = 1'b1;
            ma_next = e_addr;
            md_next = e_val;
            ml_next = e_last;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rs_reg      <= '0;
            held_reg    <= '0;
            need_reg    <= '0;
            fdb_reg     <= '0;
            sysex_reg   <= 1'b0;
            pv_reg      <= 1'b0;
            mv_reg      <= 1'b0;
            age_cnt_reg <= '0;
            for (int i = 0; i < VOICES; i++) begin
                in_use_reg[i] <= 1'b0;
                vch_reg[i]    <= '0;
                vnote_reg[i]  <= '0;
                vage_reg[i]   <= '0;
            end
            for (int c = 0; c < 16; c++) begin
                prog_tab_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;
            rs_reg    <= rs_next;
            held_reg  <= held_next;
            need_reg  <= need_next;
            fdb_reg   <= fdb_next;
            sysex_reg <= sysex_next;
            mv_reg    <= mv_next;
            if (cfg_valid && cfg_ready) begin
                pv_reg <= cfg_patches_valid;
            end
            if (act_prog) begin
                prog_tab_reg[rs_reg[3:0]] <= d1[6:0];
            end
            if (do_free) begin
                in_use_reg[free_v] <= 1'b0;
            end
            // claim the voice for the new note
            if (do_claim) begin
                in_use_reg[claim_v] <= 1'b1;
                vch_reg[claim_v]    <= ch_reg;
                vnote_reg[claim_v]  <= note_reg;
                vage_reg[claim_v]   <= age_cnt_reg + 32'd1;
                age_cnt_reg         <= age_cnt_reg + 32'd1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        pick_reg    <= pick_next;
        step_reg    <= step_next;
        ch_reg      <= ch_next;
        note_reg    <= note_next;
        prog_reg    <= prog_next;
        rel_all_reg <= rel_all_next;
        ma_reg      <= ma_next;
        md_reg      <= md_next;
        ml_reg      <= ml_next;
    end

endmodule

>>> rtl/mtf_checker.sv
// Port-level checker for the MIDI to FM register write block, with its bind.
`include "midi_to_fm_register_writes_defines.svh"

module mtf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_register_address,
    input logic [7:0] m_register_value,
    input logic       m_last_write
);

    // stalled beat holds
    `MTF_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_register_address) && $stable(m_register_value), "output beat changed while stalled")

    // more writes of the same item follow a non-final beat
    `MTF_ASSERT(a_busy_mid_item, m_valid && m_ready && !m_last_write |-> !s_ready, "input taken inside a write burst")

    // an accepted item blocks the output for no result of its own in that cycle
    `MTF_ASSERT(a_no_out_at_accept, s_valid && s_ready |-> !m_valid || m_last_write, "input accepted with a non-final write pending")

    // reset empties the output register
    `MTF_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid, "output valid after reset")

endmodule

bind midi_to_fm_register_writes mtf_checker u_mtf_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_register_address (m_register_address),
    .m_register_value   (m_register_value),
    .m_last_write       (m_last_write)
);

>>> sim/tb.sv
// Self-checking testbench for the MIDI to FM register write block.
`timescale 1ns / 100ps

module tb;
    import mtf_pkg::*;

    typedef struct {
        logic [1:0] op;
        logic [7:0] data;
        logic       last;
        logic [6:0] pnum;
        logic [3:0] ppos;
    } midi_beat_t;

    typedef struct {
        logic [7:0] addr;
        logic [7:0] value;
        logic       last;
    } fm_write_t;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [10:0] PATCH_FULL = 11'h7FF;

    logic       aclk;
    logic       aresetn;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_patches_valid;
    logic       s_valid;
    logic       s_ready;
    logic [1:0] s_opcode;
    logic [7:0] s_data_byte;
    logic       s_last_of_chunk;
    logic [6:0] s_patch_number;
    logic [3:0] s_patch_byte_position;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_register_address;
    logic [7:0] m_register_value;
    logic       m_last_write;

    midi_to_fm_register_writes u_top (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_valid             (cfg_valid),
        .cfg_ready             (cfg_ready),
        .cfg_patches_valid     (cfg_patches_valid),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_opcode              (s_opcode),
        .s_data_byte           (s_data_byte),
        .s_last_of_chunk       (s_last_of_chunk),
        .s_patch_number        (s_patch_number),
        .s_patch_byte_position (s_patch_byte_position),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_register_address    (m_register_address),
        .m_register_value      (m_register_value),
        .m_last_write          (m_last_write)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------- Predictor state ----------------
    logic [7:0]  run_status, held_byte;
    logic [1:0]  bytes_held, bytes_need;
    bit          in_sysex;
    bit          voice_busy [9];
    logic [3:0]  voice_chan [9];
    logic [6:0]  voice_key [9];
    int unsigned voice_stamp [9];
    int unsigned note_count;
    logic [6:0]  chan_patch [16];
    logic [7:0]  patch_mem [128][11];
    logic [10:0] patch_loaded [128];
    bit          patches_ok;

    fm_write_t   expected_writes [$];
    fm_write_t   write_batch [$];
    midi_beat_t  beat_queue [$];
    int          beats_sent;
    int          errors;
    bit          no_idle;

    localparam logic [9:0] FNUM_TAB [12] = '{10'h158, 10'h16D, 10'h183, 10'h19A,
        10'h1B2, 10'h1CC, 10'h1E7, 10'h204, 10'h223, 10'h244, 10'h267, 10'h28D};

    function automatic void add_write(input int addr, input int value);
        fm_write_t w;
        if (write_batch.size() >= 14) return;
        w.addr  = addr[7:0];
        w.value = value[7:0];
        w.last  = 1'b0;
        write_batch.push_back(w);
    endfunction

    function automatic void key_off(input int v);
        add_write(REG_KEY + v, 0);
        voice_busy[v] = 0;
    endfunction

    function automatic void play_note(input logic [3:0] ch, input logic [6:0] key);
        int v, prog, blk;
        bit found;
        logic [9:0] fn;
        if (!patches_ok) return;
        prog = chan_patch[ch];
        found = 0;
        v = 0;
        for (int i = 0; i < 9; i++) begin
            if (!found && !voice_busy[i]) begin
                v = i;
                found = 1;
            end
        end
        // all busy: steal the oldest, lowest index on a tie
        if (!found) begin
            for (int i = 1; i < 9; i++)
                if (voice_stamp[i] < voice_stamp[v]) v = i;
            key_off(v);
        end
        voice_busy[v] = 1;
        voice_chan[v] = ch;
        voice_key[v]  = key;
        note_count++;
        voice_stamp[v] = note_count;
        add_write(8'h20 + MOD_SLOT[v], patch_mem[prog][0]);
        add_write(8'h40 + MOD_SLOT[v], patch_mem[prog][4]);
        add_write(8'h60 + MOD_SLOT[v], patch_mem[prog][1]);
        add_write(8'h80 + MOD_SLOT[v], patch_mem[prog][2]);
        add_write(8'hE0 + MOD_SLOT[v], patch_mem[prog][3]);
        add_write(8'h20 + CAR_SLOT[v], patch_mem[prog][7]);
        add_write(8'h40 + CAR_SLOT[v], patch_mem[prog][10]);
        add_write(8'h60 + CAR_SLOT[v], patch_mem[prog][8]);
        add_write(8'h80 + CAR_SLOT[v], patch_mem[prog][9]);
        add_write(8'hE0 + CAR_SLOT[v], patch_mem[prog][5]);
        add_write(REG_FEEDBACK + v, patch_mem[prog][6] | FB_FORCE);
        blk = key / 12;
        if (blk > 7) blk = 7;
        fn = FNUM_TAB[key % 12];
        add_write(REG_FNUM_LO + v, fn[7:0]);
        add_write(REG_KEY + v, KEY_ON_BIT | (blk << 2) | fn[9:8]);
    endfunction

    function automatic void release_note(input logic [3:0] ch, input logic [6:0] key);
        for (int i = 0; i < 9; i++) begin
            if (voice_busy[i] && voice_chan[i] == ch && voice_key[i] == key) begin
                key_off(i);
                return;
            end
        end
    endfunction

    function automatic void run_message(input logic [7:0] d1, input logic [7:0] d2);
        logic [3:0] kind, ch;
        kind = run_status[7:4];
        ch   = run_status[3:0];
        if (kind == KIND_NOTE_ON) begin
            if (d2 != 0) play_note(ch, d1[6:0]);
            else release_note(ch, d1[6:0]);
        end else if (kind == KIND_NOTE_OFF) begin
            release_note(ch, d1[6:0]);
        end else if (kind == KIND_PROGRAM) begin
            chan_patch[ch] = d1[6:0];
        end else if (kind == KIND_CTRL && d1 == CC_ALL_OFF) begin
            for (int i = 0; i < 9; i++)
                if (voice_busy[i] && voice_chan[i] == ch) key_off(i);
        end
    endfunction

    function automatic logic [1:0] need_of(input logic [7:0] status);
        return (status[7:4] == KIND_PROGRAM || status[7:4] == KIND_PRESSURE) ? 2'd2 : 2'd3;
    endfunction

    function automatic void parse_byte(input logic [7:0] b, input logic last);
        if (in_sysex) begin
            if (b == SYSEX_END || last) in_sysex = 0;
            return;
        end
        if (b[7]) begin
            if (b >= REALTIME_BASE) return;
            if (b == SYSEX_START || b == SYSEX_END) begin
                run_status = 0;
                bytes_held = 0;
                if (b == SYSEX_START && !last) in_sysex = 1;
                return;
            end
            run_status = b;
            bytes_held = 1;
            bytes_need = need_of(b);
            return;
        end
        if (bytes_held == 0) begin
            if (run_status == 0) return;
            bytes_held = 1;
            bytes_need = need_of(run_status);
        end
        if (bytes_held < bytes_need) begin
            if (bytes_held == 1 && bytes_need == 3) begin
                held_byte  = b;
                bytes_held = 2;
                return;
            end
            if (bytes_need == 2) run_message(b, 8'd0);
            else run_message(held_byte, b);
            bytes_held = 1;
        end
    endfunction

    // Works out the register writes of one beat and queues them
    function automatic void predict_writes(input midi_beat_t bt);
        write_batch.delete();
        case (bt.op)
            OP_MIDI: parse_byte(bt.data, bt.last);
            OP_PATCH: begin
                if (bt.ppos < PATCH_BYTES) begin
                    patch_mem[bt.pnum][bt.ppos] = bt.data;
                    patch_loaded[bt.pnum][bt.ppos] = 1'b1;
                end
            end
            OP_RESET: begin
                for (int i = 0; i < 9; i++)
                    if (voice_busy[i]) key_off(i);
                run_status = 0;
                bytes_held = 0;
                bytes_need = 0;
                in_sysex   = 0;
            end
            default: ;
        endcase
        if (write_batch.size() > 0) write_batch[write_batch.size() - 1].last = 1'b1;
        foreach (write_batch[i]) expected_writes.push_back(write_batch[i]);
    endfunction

    // ---------------- Stimulus helpers ----------------
    function automatic logic [6:0] loaded_patch();
        logic [6:0] p;
        for (int tries = 0; tries < 20; tries++) begin
            p = 7'($urandom_range(127));
            if (patch_loaded[p] == PATCH_FULL) return p;
        end
        return ($urandom_range(1) != 0) ? 7'd127 : 7'd0;
    endfunction

    task automatic send(input logic [1:0] op, input logic [7:0] b, input logic last = 1'b0,
                        input logic [6:0] pn = 7'd0, input logic [3:0] pos = 4'd0);
        midi_beat_t bt;
        // never let a program change point a channel at a patch not fully loaded
        if (op == OP_MIDI && !in_sysex && !b[7] && run_status[7:4] == KIND_PROGRAM &&
            patch_loaded[b[6:0]] != PATCH_FULL)
            b = {1'b0, loaded_patch()};
        bt.op = op; bt.data = b; bt.last = last; bt.pnum = pn; bt.ppos = pos;
        predict_writes(bt);
        beat_queue.push_back(bt);
        beats_sent++;
    endtask

    task automatic midi(input logic [7:0] b, input logic last = 1'b0);
        send(OP_MIDI, b, last);
    endtask

    task automatic wait_idle();
        wait (beat_queue.size() == 0 && !s_valid && expected_writes.size() == 0);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_patches_valid <= value;
        do @(posedge aclk); while (!cfg_ready);
        patches_ok = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_patch(input logic [6:0] pn);
        for (int pos = 0; pos < 11; pos++)
            send(OP_PATCH, (pos == 0) ? 8'hFF : (pos == 1) ? 8'h00 : 8'($urandom_range(255)),
                 1'b0, pn, 4'(pos));
    endtask

    // One random message, mostly well formed
    task automatic random_message();
        int r;
        logic [3:0] ch;
        logic [7:0] st;
        r  = $urandom_range(99);
        ch = 4'($urandom_range(3));
        if (r < 35) begin
            st = {KIND_NOTE_ON, ch};
            if (run_status != st || $urandom_range(1) == 0) midi(st);
            midi(($urandom_range(1) != 0) ? 8'($urandom_range(127)) : 8'(60 + $urandom_range(3)));
            midi(8'($urandom_range(1, 127)), $urandom_range(9) == 0);
        end else if (r < 50) begin
            st = ($urandom_range(1) != 0) ? {KIND_NOTE_OFF, ch} : {KIND_NOTE_ON, ch};
            midi(st);
            midi(8'(60 + $urandom_range(3)));
            midi((st[7:4] == KIND_NOTE_ON) ? 8'd0 : 8'($urandom_range(127)));
        end else if (r < 55) begin
            midi({KIND_CTRL, ch}); midi(CC_ALL_OFF); midi(8'd0);
        end else if (r < 60) begin
            midi(($urandom_range(1) != 0) ? {KIND_CTRL, ch} : 8'hE0 | 8'($urandom_range(15)));
            midi(8'($urandom_range(122))); midi(8'($urandom_range(127)));
        end else if (r < 65) begin
            midi(($urandom_range(1) != 0) ? {KIND_PROGRAM, ch} : {KIND_PRESSURE, ch});
            midi({1'b0, loaded_patch()});
        end else if (r < 70) begin
            midi(8'($urandom_range(8'hF8, 8'hFF)), 1'($urandom_range(1)));
        end else if (r < 74) begin
            midi(SYSEX_START);
            repeat ($urandom_range(3)) midi(8'($urandom_range(255)));
            if ($urandom_range(1) != 0) midi(SYSEX_END);
            else midi(8'($urandom_range(255)), 1'b1);
        end else if (r < 78) begin
            midi(8'($urandom_range(8'hF1, 8'hF6)));
            midi(8'($urandom_range(127))); midi(8'($urandom_range(127)));
        end else if (r < 83) begin
            midi(8'($urandom_range(255)), $urandom_range(4) == 0);
        end else if (r < 93) begin
            send(OP_PATCH, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 ($urandom_range(1) != 0) ? 7'($urandom_range(3)) : 7'($urandom_range(127)),
                 4'($urandom_range(15)));
        end else if (r < 97) begin
            send(OP_RESET, 8'($urandom_range(255)), 1'($urandom_range(1)));
        end else begin
            send(OP_UNUSED, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 7'($urandom_range(127)), 4'($urandom_range(15)));
        end
    endtask

    // ---------------- Driver ----------------
    logic s_took;
    always @(posedge aclk) s_took <= s_valid && s_ready;

    always @(negedge aclk) begin
        midi_beat_t bt;
        m_ready <= no_idle || ($urandom_range(99) >= 30);
        if (aresetn && (!s_valid || s_took)) begin
            if (beat_queue.size() > 0 && (no_idle || $urandom_range(99) >= 30)) begin
                bt = beat_queue.pop_front();
                s_valid               <= 1'b1;
                s_opcode              <= bt.op;
                s_data_byte           <= bt.data;
                s_last_of_chunk       <= bt.last;
                s_patch_number        <= bt.pnum;
                s_patch_byte_position <= bt.ppos;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------- Monitor ----------------
    always @(posedge aclk) begin
        fm_write_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_writes.size() == 0) begin
                $display("%0t: unexpected write addr %h value %h last %b", $time,
                         m_register_address, m_register_value, m_last_write);
                errors++;
            end else begin
                w = expected_writes.pop_front();
                if (w.addr !== m_register_address) begin
                    $display("%0t: address expected %h actual %h", $time, w.addr,
                             m_register_address);
                    errors++;
                end
                if (w.value !== m_register_value) begin
                    $display("%0t: value expected %h actual %h", $time, w.value,
                             m_register_value);
                    errors++;
                end
                if (w.last !== m_last_write) begin
                    $display("%0t: last_write expected %b actual %b", $time, w.last,
                             m_last_write);
                    errors++;
                end
            end
        end
    end

    // ---------------- Sequence ----------------
    initial begin
        int target;
        aresetn = 1'b0;
        cfg_valid = 1'b0; cfg_patches_valid = 1'b0;
        s_valid = 1'b0; s_opcode = OP_MIDI; s_data_byte = 8'd0; s_last_of_chunk = 1'b0;
        s_patch_number = 7'd0; s_patch_byte_position = 4'd0;
        m_ready = 1'b0;
        errors = 0; beats_sent = 0; no_idle = 0;
        run_status = 0; held_byte = 0; bytes_held = 0; bytes_need = 0; in_sysex = 0;
        note_count = 0; patches_ok = 0;
        for (int i = 0; i < 9; i++) begin
            voice_busy[i] = 0; voice_chan[i] = 0; voice_key[i] = 0; voice_stamp[i] = 0;
        end
        for (int i = 0; i < 16; i++) chan_patch[i] = 0;
        for (int i = 0; i < 128; i++) patch_loaded[i] = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // store not loaded: note-on is ignored
        write_cfg(1'b0);
        midi(8'h90); midi(8'd60); midi(8'd100);
        load_patch(7'd0);
        load_patch(7'd127);
        send(OP_PATCH, 8'hAA, 1'b0, 7'd5, 4'd15);   // position out of range
        send(OP_UNUSED, 8'h90);
        wait_idle();
        write_cfg(1'b1);

        // directed: key extremes, running status, program, off forms
        midi(8'h90); midi(8'd0); midi(8'd127);
        midi(8'd127); midi(8'd1);                    // block capped at 7
        midi(8'hC5); midi(8'd127);
        midi(8'h95); midi(8'd60); midi(REALTIME_BASE); midi(8'd64);
        midi(8'h85); midi(8'd60); midi(8'd0);
        midi(8'h90); midi(8'd0); midi(8'd0);         // velocity zero releases
        // sysex skipped to its end, then orphan data
        midi(SYSEX_START); midi(8'h90); midi(8'd10); midi(SYSEX_END); midi(8'd33);
        midi(SYSEX_START, 1'b1); midi(8'h91); midi(8'd20); midi(8'd1, 1'b1);
        midi(SYSEX_END); midi(8'd5);
        midi(8'hF3); midi(8'd1); midi(8'd2);
        // fill every voice then steal
        midi(8'h92);
        for (int i = 0; i < 11; i++) begin
            midi(8'(40 + i)); midi(8'd90);
        end
        midi(8'hB2); midi(CC_ALL_OFF); midi(8'd0);
        midi(8'h93); midi(8'd70); midi(8'd90);
        send(OP_RESET, 8'h00);
        target = beats_sent + 16;
        while (beats_sent < target) random_message();

        // full drain with the sender held off, then a pass with the flag off
        wait_idle();
        write_cfg(1'b0);
        repeat (2) random_message();
        wait_idle();
        write_cfg(1'b1);
        no_idle = 1;
        target = beats_sent + 14;
        while (beats_sent < target) random_message();
        wait (beat_queue.size() == 0);
        no_idle = 0;
        target = beats_sent + 12;
        while (beats_sent < target) random_message();

        wait_idle();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/mtf_pkg.sv
rtl/mtf_ram.sv
rtl/midi_to_fm_register_writes.sv
rtl/mtf_checker.sv
sim/tb.sv
